// ===== rtl/pooled_doubly_linked_list_manager_top_macros.svh =====
// Assertion macros shared by the checker.
`ifndef POOLED_DOUBLY_LINKED_LIST_MANAGER_TOP_MACROS_SVH
`define POOLED_DOUBLY_LINKED_LIST_MANAGER_TOP_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define PDL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define PDL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pdllm_pkg.sv =====
`timescale 1ns / 1ps
package pdllm_pkg;
  localparam int NumNodes = 128;
  localparam int NumLists = 16;
  localparam int ItemBits = 32;
  localparam int NodeW = 8;
  localparam int NodeIdxW = $clog2(NumNodes);
  localparam int ListW = 4;
  localparam int CntW = 8;
  localparam logic [NodeW-1:0] Nil = 8'hFF;

  localparam logic [2:0] ReqCreate = 3'd0;
  localparam logic [2:0] ReqCount = 3'd1;
  localparam logic [2:0] ReqFirst = 3'd2;
  localparam logic [2:0] ReqCurrent = 3'd3;
  localparam logic [2:0] ReqAdd = 3'd4;
  localparam logic [2:0] ReqAppend = 3'd5;
  localparam logic [2:0] ReqRemove = 3'd6;
  localparam logic [2:0] ReqFree = 3'd7;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoHead = 2'd1;
  localparam logic [1:0] StNoNode = 2'd2;
  localparam logic [1:0] StNothing = 2'd3;

  localparam logic [1:0] ModeBefore = 2'd0;
  localparam logic [1:0] ModeInside = 2'd1;
  localparam logic [1:0] ModeBeyond = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [ListW-1:0] list_sel;
    logic [31:0] item_word;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [ListW-1:0] list_out;
    logic [31:0] item_out;
    logic [CntW-1:0] count_out;
  } rsp_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;     // latch request, read list state
    logic rd_node;  // read node at address
    logic [1:0] rd_sel; // 0 head/cursor,1 next of cursor,2 head
    logic exec;     // perform update for request
    logic walk;     // free one node and step
    logic finish;   // free: release head, clear list
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic walk_done;
  } sts_t;
endpackage

// ===== rtl/pdllm_if.sv =====
`timescale 1ns / 1ps
interface pdllm_req_if;
  logic valid;
  logic ready;
  pdllm_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pdllm_rsp_if;
  logic valid;
  logic ready;
  pdllm_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/pdllm_ram.sv =====
`timescale 1ns / 1ps
module pdllm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/pdllm_ctrl.sv =====
`timescale 1ns / 1ps
module pdllm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [2:0]          in_req_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pdllm_pkg::cmd_t     cmd_o,
  input  pdllm_pkg::sts_t     sts_i
);
  import pdllm_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRd0 = 3'd1;
  localparam logic [2:0] SRd1 = 3'd2;
  localparam logic [2:0] SRd2 = 3'd3;
  localparam logic [2:0] SExec = 3'd4;
  localparam logic [2:0] SWalk = 3'd5;
  localparam logic [2:0] SFin = 3'd6;
  localparam logic [2:0] SOut = 3'd7;

  logic [2:0] state_q, state_d;
  logic [2:0] req_q, req_d;

  assign in_ready_o = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    cmd_o = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          req_d = in_req_i;
          state_d = SRd0;
        end
      end
      SRd0: begin
        // list state now registered; fetch cursor's node links (head's for first and free)
        cmd_o.rd_node = 1'b1;
        cmd_o.rd_sel = 2'd0;
        state_d = (req_q == ReqFree) ? SWalk : SRd1;
      end
      SRd1: begin
        cmd_o.rd_node = 1'b1;
        cmd_o.rd_sel = 2'd1;
        state_d = SRd2;
      end
      SRd2: begin
        cmd_o.rd_node = 1'b1;
        cmd_o.rd_sel = 2'd2;
        state_d = SExec;
      end
      SExec: begin
        cmd_o.exec = 1'b1;
        state_d = SOut;
      end
      SWalk: begin
        if (sts_i.walk_done) begin
          state_d = SFin;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      SFin: begin
        cmd_o.finish = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      req_q <= ReqCount;
    end else begin
      state_q <= state_d;
      req_q <= req_d;
    end
  end
endmodule

// ===== rtl/pdllm_dp.sv =====
`timescale 1ns / 1ps
module pdllm_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdllm_pkg::req_t   req_i,
  input  pdllm_pkg::cmd_t   cmd_i,
  output pdllm_pkg::sts_t   sts_o,
  output pdllm_pkg::rsp_t   rsp_o
);
  import pdllm_pkg::*;

  localparam int LIdxW = $clog2(NumLists);

  // list table in flops (16 entries)
  logic [NodeW-1:0] head_q [NumLists];
  logic [NodeW-1:0] tail_q [NumLists];
  logic [NodeW-1:0] cur_q [NumLists];
  logic [CntW-1:0] len_q [NumLists];
  logic [1:0] mode_q [NumLists];
  logic [ListW-1:0] fh_ring_q [NumLists];
  logic [LIdxW-1:0] fh_front_q;
  logic [LIdxW:0] fh_total_q;
  logic [NodeIdxW-1:0] fn_front_q;
  logic [NodeIdxW:0] fn_total_q;
  logic [NumNodes-1:0] fn_wr_q; // ring entries overwritten since reset

  req_t r_q;
  logic [LIdxW-1:0] l_q;
  logic [NodeW-1:0] h_q, t_q, c_q, cn_q, cp_q, n_q;
  logic [NodeW-1:0] walk_n_q;
  logic [CntW-1:0] walk_i_q;
  logic [ItemBits-1:0] cval_q, hval_q;
  rsp_t rsp_q;

  // memories
  logic nv_we, nn_we, np_we, nn_we2, np_we2, fr_we;
  logic [NodeIdxW-1:0] nv_wa, nn_wa, np_wa, nn_wa2, np_wa2, rd_a, fr_wa, fr_ra;
  logic [ItemBits-1:0] nv_wd, nv_rd;
  logic [NodeW-1:0] nn_wd, np_wd, nn_wd2, np_wd2, nn_rd, np_rd;
  logic [NodeIdxW-1:0] fr_wd, fr_rd;

  // one link write per port per cycle; second link write goes to a second bank
  // pair and the newer value is chosen on read by a per-node bank bit
  logic [NumNodes-1:0] nbank_q, pbank_q;
  logic [NodeW-1:0] nn_rd2, np_rd2;
  logic [NodeIdxW-1:0] rd_a_q;

  pdllm_ram #(.Width(ItemBits), .Depth(NumNodes)) u_val (
    .clk_i, .we_i(nv_we), .waddr_i(nv_wa), .wdata_i(nv_wd), .raddr_i(rd_a), .rdata_o(nv_rd));
  pdllm_ram #(.Width(NodeW), .Depth(NumNodes)) u_nxt0 (
    .clk_i, .we_i(nn_we), .waddr_i(nn_wa), .wdata_i(nn_wd), .raddr_i(rd_a), .rdata_o(nn_rd));
  pdllm_ram #(.Width(NodeW), .Depth(NumNodes)) u_nxt1 (
    .clk_i, .we_i(nn_we2), .waddr_i(nn_wa2), .wdata_i(nn_wd2), .raddr_i(rd_a),
    .rdata_o(nn_rd2));
  pdllm_ram #(.Width(NodeW), .Depth(NumNodes)) u_prv0 (
    .clk_i, .we_i(np_we), .waddr_i(np_wa), .wdata_i(np_wd), .raddr_i(rd_a), .rdata_o(np_rd));
  pdllm_ram #(.Width(NodeW), .Depth(NumNodes)) u_prv1 (
    .clk_i, .we_i(np_we2), .waddr_i(np_wa2), .wdata_i(np_wd2), .raddr_i(rd_a),
    .rdata_o(np_rd2));
  pdllm_ram #(.Width(NodeIdxW), .Depth(NumNodes)) u_fring (
    .clk_i, .we_i(fr_we), .waddr_i(fr_wa), .wdata_i(fr_wd), .raddr_i(fr_ra), .rdata_o(fr_rd));

  logic [NodeW-1:0] nxt_rd, prv_rd;
  logic [NodeIdxW-1:0] fr_ra_q;
  assign nxt_rd = nbank_q[rd_a_q] ? nn_rd2 : nn_rd;
  assign prv_rd = pbank_q[rd_a_q] ? np_rd2 : np_rd;

  function automatic logic vld(input logic [NodeW-1:0] n);
    return n < NodeW'(NumNodes);
  endfunction

  // new node from the free ring (identity until an entry is rewritten)
  logic [NodeIdxW-1:0] take_n;
  assign take_n = fn_wr_q[fr_ra_q] ? fr_rd : fr_ra_q;
  assign fr_ra = fn_front_q;

  // walk bookkeeping
  logic walk_first_q;

  // node read address by phase; during the walk the address of the node being
  // freed is held through the first walk step, then follows the next link
  always_comb begin
    unique case (cmd_i.rd_sel)
      2'd0: rd_a = (cmd_i.load) ? '0 : c_q[NodeIdxW-1:0];
      2'd1: rd_a = cn_q[NodeIdxW-1:0];
      default: rd_a = h_q[NodeIdxW-1:0];
    endcase
    if (cmd_i.walk) rd_a = walk_first_q ? walk_n_q[NodeIdxW-1:0] : nxt_rd[NodeIdxW-1:0];
    if (cmd_i.rd_node && cmd_i.rd_sel == 2'd0 && r_q.req_type == ReqFree)
      rd_a = h_q[NodeIdxW-1:0];
    if (cmd_i.rd_node && cmd_i.rd_sel == 2'd0 && r_q.req_type == ReqFirst)
      rd_a = h_q[NodeIdxW-1:0];
  end

  // first read phase gives links and value of the cursor (head for first and
  // free); the later phases are spare reads
  always_ff @(posedge clk_i) begin
    rd_a_q <= rd_a;
    fr_ra_q <= fr_ra;
  end

  logic [1:0] phase_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phase_q <= '0;
    else if (cmd_i.rd_node) phase_q <= cmd_i.rd_sel + 2'd1;
    else phase_q <= '0;
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == 2'd1) begin
      cn_q <= nxt_rd;
      cp_q <= prv_rd;
      cval_q <= nv_rd;
      hval_q <= nv_rd;
    end
  end

  assign sts_o.walk_done = !walk_first_q &&
    (walk_i_q >= len_q[l_q] || walk_i_q >= CntW'(NumNodes) || !vld(walk_n_q));

  logic [LIdxW-1:0] lsel;
  assign lsel = req_i.list_sel[LIdxW-1:0];

  always_comb begin
    nv_we = 1'b0; nv_wa = '0; nv_wd = '0;
    nn_we = 1'b0; nn_wa = '0; nn_wd = '0;
    nn_we2 = 1'b0; nn_wa2 = '0; nn_wd2 = '0;
    np_we = 1'b0; np_wa = '0; np_wd = '0;
    np_we2 = 1'b0; np_wa2 = '0; np_wd2 = '0;
    fr_we = 1'b0; fr_wa = '0; fr_wd = '0;
    if (cmd_i.exec) begin
      if ((r_q.req_type == ReqAdd || r_q.req_type == ReqAppend) && fn_total_q != '0) begin
        nv_we = 1'b1; nv_wa = take_n; nv_wd = r_q.item_word[ItemBits-1:0];
        nn_we = 1'b1; nn_wa = take_n; np_we = 1'b1; np_wa = take_n;
        if (len_q[l_q] == '0) begin
          nn_wd = Nil; np_wd = Nil;
        end else if (r_q.req_type == ReqAdd && mode_q[l_q] == ModeBefore) begin
          nn_wd = h_q; np_wd = Nil;
          np_we2 = vld(h_q); np_wa2 = h_q[NodeIdxW-1:0]; np_wd2 = {1'b0, take_n};
        end else if (r_q.req_type == ReqAppend || mode_q[l_q] == ModeBeyond ||
                     c_q == t_q || !vld(c_q)) begin
          np_wd = t_q; nn_wd = Nil;
          nn_we2 = vld(t_q); nn_wa2 = t_q[NodeIdxW-1:0]; nn_wd2 = {1'b0, take_n};
        end else begin
          np_wd = c_q; nn_wd = cn_q;
          np_we2 = vld(cn_q); np_wa2 = cn_q[NodeIdxW-1:0]; np_wd2 = {1'b0, take_n};
          nn_we2 = 1'b1; nn_wa2 = c_q[NodeIdxW-1:0]; nn_wd2 = {1'b0, take_n};
        end
      end else if (r_q.req_type == ReqRemove && len_q[l_q] != '0 &&
                   fn_total_q < (NodeIdxW+1)'(NumNodes) &&
                   mode_q[l_q] == ModeInside && vld(c_q)) begin
        if (h_q == t_q) begin
        end else if (c_q == h_q) begin
          np_we2 = vld(cn_q); np_wa2 = cn_q[NodeIdxW-1:0]; np_wd2 = Nil;
        end else if (c_q == t_q) begin
          nn_we2 = vld(cp_q); nn_wa2 = cp_q[NodeIdxW-1:0]; nn_wd2 = Nil;
        end else begin
          nn_we2 = vld(cp_q); nn_wa2 = cp_q[NodeIdxW-1:0]; nn_wd2 = cn_q;
          np_we2 = vld(cn_q); np_wa2 = cn_q[NodeIdxW-1:0]; np_wd2 = cp_q;
        end
        fr_we = 1'b1;
        fr_wa = NodeIdxW'(fn_front_q + fn_total_q[NodeIdxW-1:0]);
        fr_wd = c_q[NodeIdxW-1:0];
      end
    end
    if (cmd_i.walk && !walk_first_q && fn_total_q < (NodeIdxW+1)'(NumNodes)) begin
      fr_we = 1'b1;
      fr_wa = NodeIdxW'(fn_front_q + fn_total_q[NodeIdxW-1:0]);
      fr_wd = walk_n_q[NodeIdxW-1:0];
    end
  end

  logic fr_give;
  assign fr_give = fr_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLists; i++) begin
        head_q[i] <= Nil; tail_q[i] <= Nil; cur_q[i] <= Nil;
        len_q[i] <= '0; mode_q[i] <= ModeBefore;
        fh_ring_q[i] <= ListW'(i);
      end
      fh_front_q <= '0;
      fh_total_q <= (LIdxW+1)'(NumLists);
      fn_front_q <= '0;
      fn_total_q <= (NodeIdxW+1)'(NumNodes);
      fn_wr_q <= '0;
      nbank_q <= '0;
      pbank_q <= '0;
      walk_first_q <= 1'b0;
      walk_i_q <= '0;
      walk_n_q <= Nil;
    end else begin
      if (nn_we) nbank_q[nn_wa] <= 1'b0;
      if (nn_we2) nbank_q[nn_wa2] <= 1'b1;
      if (np_we) pbank_q[np_wa] <= 1'b0;
      if (np_we2) pbank_q[np_wa2] <= 1'b1;
      if (fr_give) begin
        fn_wr_q[fr_wa] <= 1'b1;
        fn_total_q <= fn_total_q + 1'b1;
      end
      if (cmd_i.load) walk_first_q <= 1'b1;
      if (cmd_i.rd_node && cmd_i.rd_sel == 2'd0 && r_q.req_type == ReqFree) begin
        walk_n_q <= h_q;
        walk_i_q <= '0;
      end
      if (cmd_i.walk) begin
        walk_first_q <= 1'b0;
        if (!walk_first_q) begin
          walk_n_q <= nxt_rd;
          walk_i_q <= walk_i_q + 1'b1;
        end
      end
      if (cmd_i.exec) begin
        unique case (r_q.req_type)
          ReqCreate: begin
            if (fh_total_q != '0) begin
              fh_front_q <= fh_front_q + 1'b1;
              fh_total_q <= fh_total_q - 1'b1;
              head_q[n_q[LIdxW-1:0]] <= Nil; tail_q[n_q[LIdxW-1:0]] <= Nil;
              cur_q[n_q[LIdxW-1:0]] <= Nil; len_q[n_q[LIdxW-1:0]] <= '0;
              mode_q[n_q[LIdxW-1:0]] <= ModeBefore;
            end
          end
          ReqFirst: begin
            if (len_q[l_q] == '0) cur_q[l_q] <= Nil;
            else begin
              cur_q[l_q] <= h_q; mode_q[l_q] <= ModeInside;
            end
          end
          ReqAdd, ReqAppend: begin
            if (fn_total_q != '0) begin
              fn_front_q <= fn_front_q + 1'b1;
              fn_total_q <= fn_total_q - 1'b1;
              if (len_q[l_q] == '0) begin
                head_q[l_q] <= {1'b0, take_n}; tail_q[l_q] <= {1'b0, take_n};
              end else if (r_q.req_type == ReqAdd && mode_q[l_q] == ModeBefore) begin
                head_q[l_q] <= {1'b0, take_n};
              end else if (r_q.req_type == ReqAppend || mode_q[l_q] == ModeBeyond ||
                           c_q == t_q || !vld(c_q)) begin
                tail_q[l_q] <= {1'b0, take_n};
              end
              cur_q[l_q] <= {1'b0, take_n};
              mode_q[l_q] <= ModeInside;
              if (len_q[l_q] != '1) len_q[l_q] <= len_q[l_q] + 1'b1;
            end
          end
          ReqRemove: begin
            if (len_q[l_q] == '0 || fn_total_q >= (NodeIdxW+1)'(NumNodes)) begin
              mode_q[l_q] <= ModeBefore;
            end else if (mode_q[l_q] == ModeInside && vld(c_q)) begin
              if (h_q == t_q) begin
                head_q[l_q] <= Nil; tail_q[l_q] <= Nil; cur_q[l_q] <= Nil;
                mode_q[l_q] <= ModeBeyond;
              end else if (c_q == h_q) begin
                head_q[l_q] <= cn_q; cur_q[l_q] <= cn_q;
              end else if (c_q == t_q) begin
                tail_q[l_q] <= cp_q; cur_q[l_q] <= Nil; mode_q[l_q] <= ModeBeyond;
              end else begin
                cur_q[l_q] <= cn_q;
              end
              len_q[l_q] <= len_q[l_q] - 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        if (fh_total_q < (LIdxW+1)'(NumLists)) begin
          fh_ring_q[LIdxW'(fh_front_q + fh_total_q[LIdxW-1:0])] <= ListW'(l_q);
          fh_total_q <= fh_total_q + 1'b1;
        end
        head_q[l_q] <= Nil; tail_q[l_q] <= Nil; cur_q[l_q] <= Nil;
        len_q[l_q] <= '0; mode_q[l_q] <= ModeBefore;
      end
    end
  end

  // latch request and list snapshot
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q <= req_i;
      l_q <= (req_i.req_type == ReqCreate) ? fh_ring_q[fh_front_q][LIdxW-1:0] : lsel;
      n_q <= NodeW'(fh_ring_q[fh_front_q][LIdxW-1:0]);
      h_q <= head_q[(req_i.req_type == ReqCreate) ? fh_ring_q[fh_front_q][LIdxW-1:0] : lsel];
      t_q <= tail_q[lsel];
      c_q <= cur_q[lsel];
    end
  end

  // response formed at exec/finish, held until transferred
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_q <= '{status: StOk, list_out: '0, item_out: '0, count_out: '0};
    end else if (cmd_i.exec) begin
      rsp_q.list_out <= '0;
      rsp_q.item_out <= '0;
      rsp_q.status <= StOk;
      rsp_q.count_out <= len_q[l_q];
      unique case (r_q.req_type)
        ReqCreate: begin
          if (fh_total_q == '0) begin
            rsp_q.status <= StNoHead; rsp_q.count_out <= '0;
          end else begin
            rsp_q.list_out <= ListW'(l_q); rsp_q.count_out <= '0;
          end
        end
        ReqFirst: begin
          if (len_q[l_q] == '0) rsp_q.status <= StNothing;
          else rsp_q.item_out <= 32'(hval_q);
        end
        ReqCurrent: begin
          if (len_q[l_q] == '0 || mode_q[l_q] != ModeInside || !vld(c_q))
            rsp_q.status <= StNothing;
          else rsp_q.item_out <= 32'(cval_q);
        end
        ReqAdd, ReqAppend: begin
          if (fn_total_q == '0) rsp_q.status <= StNoNode;
          else if (len_q[l_q] != '1) rsp_q.count_out <= len_q[l_q] + 1'b1;
        end
        ReqRemove: begin
          if (len_q[l_q] == '0 || fn_total_q >= (NodeIdxW+1)'(NumNodes) ||
              mode_q[l_q] != ModeInside || !vld(c_q)) begin
            rsp_q.status <= StNothing;
          end else begin
            rsp_q.item_out <= 32'(cval_q);
            rsp_q.count_out <= len_q[l_q] - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp_o = rsp_q;
endmodule

// ===== rtl/pooled_doubly_linked_list_manager_top.sv =====
`timescale 1ns / 1ps
// Pooled doubly linked list manager: up to 16 lists over a shared pool of 128
// nodes. One request in, one response out per transfer. A request other than
// free goes from its transfer to the next ready through latch, three node-memory
// reads, update and response; the response register holds for as long as the
// output stalls. Free reads the head, spends a first walk step lining up the
// link read, then walks the list one node per cycle through the node-link
// memory, then releases the head and clears the list.
// A new request is taken only after the previous response transfers. No
// clearing pass after reset.
module pooled_doubly_linked_list_manager_top (
  input logic clk_i,
  input logic rst_ni,
  pdllm_req_if.sink req_i,
  pdllm_rsp_if.source rsp_o
);
  import pdllm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;

  // controller sequences the datapath phases
  pdllm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req_i.valid), .in_req_i(req_i.payload.req_type),
    .in_ready_o(req_i.ready),
    .out_valid_o(rsp_o.valid), .out_ready_i(rsp_o.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  // datapath holds list table, rings and node memories
  pdllm_dp u_dp (
    .clk_i, .rst_ni, .req_i(req_i.payload), .cmd_i(cmd), .sts_o(sts), .rsp_o(rsp)
  );

  assign rsp_o.payload = rsp;
endmodule

// ===== rtl/pdllm_chk.sv =====
`timescale 1ns / 1ps
`include "pooled_doubly_linked_list_manager_top_macros.svh"
module pdllm_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status
);
  `PDL_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid, !in_ready, "accept while response pending")
  `PDL_ASSERT_NXT(a_busy, clk_i, rst_ni, in_valid && in_ready, !in_ready, "ready after accept")
  `PDL_ASSERT_NXT(a_done, clk_i, rst_ni, out_valid && out_ready, !out_valid, "double response")
  `PDL_ASSERT_IMP(a_stat, clk_i, rst_ni, out_valid && $past(out_valid), $stable(status),
    "status moved")
endmodule

bind pooled_doubly_linked_list_manager_top pdllm_chk u_chk (
  .clk_i, .rst_ni, .in_valid(req_i.valid), .in_ready(req_i.ready),
  .out_valid(rsp_o.valid), .out_ready(rsp_o.ready), .status(rsp_o.payload.status)
);
